// File: hw/rtl/ctpi_pkg.sv
// ============================================================================
// ctpi_pkg: shared types and constants for the polar conversion pipeline
// Datapath widths, angle constants, arctangent table and the gain function.
// ============================================================================
package ctpi_pkg;

	localparam int IN_W      = 16;
	localparam int IN_SHIFT  = 14;
	localparam int XW        = 34;
	localparam int ZW        = 32;
	localparam int TW        = ZW - 1;
	localparam int KW        = 31;
	localparam int PW        = 64;
	localparam int MAG_W     = 20;
	localparam int PH_W      = 16;
	localparam int TABLE_LEN = 24;

	localparam logic [TW-1:0] ANG_PI_2  = 31'd421657428;
	localparam logic [TW-1:0] ANG_PI    = 31'd843314857;
	localparam logic [TW-1:0] ANG_3PI_2 = 31'd1264972285;
	localparam logic [TW-1:0] ANG_2PI   = 31'd1686629713;

	localparam logic [MAG_W-1:0] MAG_MAX   = 20'd741455;
	localparam logic [PH_W-1:0]  PHASE_MAX = 16'd51471;

	// atan(2^-i) in radians, 28 fraction bits
	localparam logic signed [ZW-1:0] ATAN_Q28 [TABLE_LEN] = '{
		32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
		32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
		32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
		32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
		32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
		32'sd256,       32'sd128,       32'sd64,       32'sd32
	};

	typedef struct packed {
		logic re_neg;
		logic im_neg;
		logic re_zero;
		logic im_zero;
	} ctpi_quad_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		ctpi_quad_t           quad;
	} ctpi_data_t;

	// Inverse CORDIC gain with 30 fraction bits, evaluated at elaboration.
	function automatic logic [63:0] ctpi_inv_gain(input int n);
		logic [63:0] p;
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] bitv;
		logic [63:0] rem;
		logic [63:0] quo;
		p = 64'd1 << 32;
		for (int i = 0; i < n; i++) begin
			p = p + (p >> (2 * i));
		end
		v = p << 28;
		res = 64'd0;
		bitv = 64'd1 << 62;
		for (int k = 0; k < 32; k++) begin
			if (bitv > v) begin
				bitv = bitv >> 2;
			end
		end
		for (int k = 0; k < 32; k++) begin
			if (bitv != 64'd0) begin
				if (v >= res + bitv) begin
					v = v - (res + bitv);
					res = (res >> 1) + bitv;
				end else begin
					res = res >> 1;
				end
				bitv = bitv >> 2;
			end
		end
		if (res == 64'd0) begin
			res = 64'd1;
		end
		// long division of 2^60 by res
		rem = 64'd0;
		quo = 64'd0;
		for (int b = 60; b >= 0; b--) begin
			rem = (rem << 1) | ((b == 60) ? 64'd1 : 64'd0);
			if (rem >= res) begin
				rem = rem - res;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

endpackage

// File: hw/rtl/ctpi_cell.sv
// ============================================================================
// ctpi_cell: one CORDIC vectoring stage
// Rotates (x, y) by +/- atan(2^-SHIFT) toward y = 0 and registers the result.
// ============================================================================
module ctpi_cell
	import ctpi_pkg::*;
#(
	parameter int SHIFT = 0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       valid_in,
	input  ctpi_data_t data_in,
	output logic       valid_out,
	output ctpi_data_t data_out
);

	logic signed [XW-1:0] x_in;
	logic signed [XW-1:0] y_in;
	logic signed [XW-1:0] dx;
	logic signed [XW-1:0] dy;
	ctpi_data_t           nxt;
	logic                 valid_q;
	ctpi_data_t           data_q;

	always_comb begin
		x_in = data_in.x;
		y_in = data_in.y;
		dx   = y_in >>> SHIFT;
		dy   = x_in >>> SHIFT;
		nxt  = data_in;
		if (!y_in[XW-1]) begin
			nxt.x = x_in + dx;
			nxt.y = y_in - dy;
			nxt.z = data_in.z + ATAN_Q28[SHIFT];
		end else begin
			nxt.x = x_in - dx;
			nxt.y = y_in + dy;
			nxt.z = data_in.z - ATAN_Q28[SHIFT];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	assign valid_out = valid_q;
	assign data_out  = data_q;

endmodule

// File: hw/rtl/ctpi_post.sv
// ============================================================================
// ctpi_post: gain correction and quadrant restore
// Two stages: gain multiply and angle select, then rounding and saturation.
// ============================================================================
module ctpi_post
	import ctpi_pkg::*;
#(
	parameter int STAGES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              valid_in,
	input  ctpi_data_t        data_in,
	output logic              valid_out,
	output logic [MAG_W-1:0]  magnitude,
	output logic [PH_W-1:0]   phase
);

	localparam logic [KW-1:0] INV_GAIN = KW'(ctpi_inv_gain(STAGES));

	logic [XW-2:0]    x_u;
	logic [TW-1:0]    z_c;
	logic [TW-1:0]    theta;
	logic [PW-1:0]    mag_sum;
	logic [23:0]      mag_r;
	logic [TW:0]      ph_sum;
	logic [16:0]      ph_r;

	logic             valid_s1;
	logic [PW-1:0]    prod_s1;
	logic [TW-1:0]    theta_s1;
	logic             valid_s2;
	logic [MAG_W-1:0] mag_s2;
	logic [PH_W-1:0]  phase_s2;

	always_comb begin
		x_u = data_in.x[XW-1] ? '0 : data_in.x[XW-2:0];
		if (data_in.z[ZW-1]) begin
			z_c = '0;
		end else if (data_in.z[ZW-2:0] > ANG_PI_2) begin
			z_c = ANG_PI_2;
		end else begin
			z_c = data_in.z[ZW-2:0];
		end
		if (data_in.quad.im_zero) begin
			theta = data_in.quad.re_neg ? ANG_PI : '0;
		end else if (data_in.quad.re_zero) begin
			theta = data_in.quad.im_neg ? ANG_3PI_2 : ANG_PI_2;
		end else if (!data_in.quad.re_neg && !data_in.quad.im_neg) begin
			theta = z_c;
		end else if (data_in.quad.re_neg && !data_in.quad.im_neg) begin
			theta = ANG_PI - z_c;
		end else if (data_in.quad.re_neg) begin
			theta = ANG_PI + z_c;
		end else begin
			theta = ANG_2PI - z_c;
		end
	end

	always_comb begin
		mag_sum = prod_s1 + (64'd1 << 39);
		mag_r   = mag_sum[63:40];
		ph_sum  = {1'b0, theta_s1} + 32'd16384;
		ph_r    = ph_sum[TW:15];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1  <= PW'(x_u) * PW'(INV_GAIN);
			theta_s1 <= theta;
			mag_s2   <= (mag_r > 24'(MAG_MAX)) ? MAG_MAX : mag_r[MAG_W-1:0];
			phase_s2 <= (ph_r > 17'(PHASE_MAX)) ? '0 : ph_r[PH_W-1:0];
		end
	end

	assign valid_out = valid_s2;
	assign magnitude = mag_s2;
	assign phase     = phase_s2;

endmodule

// File: hw/rtl/complex_to_polar_impedance_unit.sv
// ============================================================================
// complex_to_polar_impedance_unit: CORDIC rectangular to polar converter
// Throughput: one transaction per cycle while the output is not stalled; one
// input register, one cell per rotation stage (capped at the arctangent table
// length), then two output stages (gain multiply, rounding).
// The whole pipeline halts while a result waits under stall.
// Reset clears the valid bits only; no clearing pass.
// ============================================================================
module complex_to_polar_impedance_unit
	import ctpi_pkg::*;
#(
	parameter int ROTATION_STAGES = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    sample_valid,
	output logic                    sample_stall,
	input  logic signed [IN_W-1:0]  real_part,
	input  logic signed [IN_W-1:0]  imag_part,
	output logic                    result_valid,
	input  logic                    result_stall,
	output logic [MAG_W-1:0]        magnitude,
	output logic [PH_W-1:0]         phase
);

	localparam int STAGES = (ROTATION_STAGES > TABLE_LEN) ? TABLE_LEN : ROTATION_STAGES;

	logic        en;
	logic [16:0] re_abs;
	logic [16:0] im_abs;
	ctpi_data_t  in_d;
	logic        valid_q;
	ctpi_data_t  data_q;
	logic        cv [STAGES+1];
	ctpi_data_t  cd [STAGES+1];

	assign en           = !(result_valid && result_stall);
	assign sample_stall = !en;

	always_comb begin
		re_abs = real_part[IN_W-1] ? (17'd0 - {1'b1, real_part}) : {1'b0, real_part};
		im_abs = imag_part[IN_W-1] ? (17'd0 - {1'b1, imag_part}) : {1'b0, imag_part};
		in_d.x = {{(XW-17-IN_SHIFT){1'b0}}, re_abs, {IN_SHIFT{1'b0}}};
		in_d.y = {{(XW-17-IN_SHIFT){1'b0}}, im_abs, {IN_SHIFT{1'b0}}};
		in_d.z = '0;
		in_d.quad.re_neg  = real_part[IN_W-1];
		in_d.quad.im_neg  = imag_part[IN_W-1];
		in_d.quad.re_zero = (real_part == '0);
		in_d.quad.im_zero = (imag_part == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= in_d;
		end
	end

	assign cv[0] = valid_q;
	assign cd[0] = data_q;

	for (genvar g = 0; g < STAGES; g++) begin : g_cell
		ctpi_cell #(
			.SHIFT (g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (cv[g]),
			.data_in   (cd[g]),
			.valid_out (cv[g+1]),
			.data_out  (cd[g+1])
		);
	end

	ctpi_post #(
		.STAGES (STAGES)
	) u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (cv[STAGES]),
		.data_in   (cd[STAGES]),
		.valid_out (result_valid),
		.magnitude (magnitude),
		.phase     (phase)
	);

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall) |=> valid_q)
		else $error("accepted transaction did not enter the pipeline");

	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (result_valid && result_stall))
		else $error("input stalled without output back pressure");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (phase <= PHASE_MAX))
		else $error("phase beyond full turn");

	a_mag_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (magnitude <= MAG_MAX))
		else $error("magnitude beyond saturation limit");

endmodule

// File: tb/tb_top.sv
// ============================================================================
// tb_top: testbench for complex_to_polar_impedance_unit
// Drives signed real/imaginary pairs through the valid/stall handshake and
// checks each magnitude and phase against a bit-accurate CORDIC vectoring
// predictor. Directed corner pairs come first, then random pairs. Both sides
// idle and stall in random bursts, with one long receiver hold-off and
// pauses where the sender waits for the pipeline to drain.
// ============================================================================
module tb_top;
	import ctpi_pkg::*;

	localparam int STAGES     = 16;
	localparam int USED_STAGE = (STAGES > 24) ? 24 : STAGES;
	localparam int LATENCY    = STAGES + 3;
	localparam int HOLD_CYC   = 100;

	localparam longint Q_PI_2  = 64'sd421657428;
	localparam longint Q_PI    = 64'sd843314857;
	localparam longint Q_3PI_2 = 64'sd1264972285;
	localparam longint Q_2PI   = 64'sd1686629713;
	localparam logic [19:0] MAG_SAT = 20'd741455;
	localparam logic [15:0] PH_TOP  = 16'd51471;

	localparam longint ATAN_TBL [24] = '{
		210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
		4193963, 2097109, 1048571, 524287, 262144, 131072,
		65536, 32768, 16384, 8192, 4096, 2048,
		1024, 512, 256, 128, 64, 32
	};

	typedef struct {
		logic signed [IN_W-1:0] re;
		logic signed [IN_W-1:0] im;
		bit                     drain;
	} sample_t;

	typedef struct {
		logic signed [IN_W-1:0] re;
		logic signed [IN_W-1:0] im;
		logic [MAG_W-1:0]       mag;
		logic [PH_W-1:0]        ph;
	} polar_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   sample_valid = 1'b0;
	logic                   sample_stall;
	logic signed [IN_W-1:0] real_part = '0;
	logic signed [IN_W-1:0] imag_part = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	logic [MAG_W-1:0]       magnitude;
	logic [PH_W-1:0]        phase;

	sample_t     pending_samples[$];
	polar_t      awaited_polar[$];
	logic [63:0] inv_gain;
	logic        in_took = 1'b0;
	int          n_total = 0;
	int          n_sent = 0;
	int          n_in = 0;
	int          n_out = 0;
	int          n_err = 0;
	int          in_gap = 0;
	int          stall_left = 0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;
	int          n_drains = 0;

	complex_to_polar_impedance_unit #(
		.ROTATION_STAGES(STAGES)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.real_part   (real_part),
		.imag_part   (imag_part),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.magnitude   (magnitude),
		.phase       (phase)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// 1/gain with 30 fraction bits
	function automatic logic [63:0] cordic_inv_gain(input int n);
		logic [63:0] p;
		logic [63:0] v;
		logic [63:0] root;
		logic [63:0] b;
		p = 64'd1 << 32;
		for (int i = 0; i < n; i++) begin
			p = p + (p >> (2 * i));
		end
		v = p << 28;
		root = 64'd0;
		b = 64'd1 << 62;
		while (b > v) begin
			b = b >> 2;
		end
		while (b != 64'd0) begin
			if (v >= root + b) begin
				v = v - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		if (root == 64'd0) begin
			root = 64'd1;
		end
		return (64'd1 << 60) / root;
	endfunction

	function automatic polar_t polar_of(input logic signed [IN_W-1:0] re,
			input logic signed [IN_W-1:0] im);
		polar_t      r;
		longint      re_l;
		longint      im_l;
		longint      x;
		longint      y;
		longint      z;
		longint      dx;
		longint      dy;
		longint      theta;
		logic [63:0] prod;
		logic [63:0] pr;
		re_l = re;
		im_l = im;
		x = (re_l < 0 ? -re_l : re_l) * 16384;
		y = (im_l < 0 ? -im_l : im_l) * 16384;
		z = 0;
		for (int i = 0; i < USED_STAGE; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x = x + dx;
				y = y - dy;
				z = z + ATAN_TBL[i];
			end else begin
				x = x - dx;
				y = y + dy;
				z = z - ATAN_TBL[i];
			end
		end
		if (x < 0) begin
			x = 0;
		end
		prod = (64'(x) * inv_gain + (64'd1 << 39)) >> 40;
		if (prod > 64'(MAG_SAT)) begin
			prod = 64'(MAG_SAT);
		end
		if (z < 0) begin
			z = 0;
		end
		if (z > Q_PI_2) begin
			z = Q_PI_2;
		end
		if (im_l == 0) begin
			theta = (re_l < 0) ? Q_PI : 0;
		end else if (re_l == 0) begin
			theta = (im_l > 0) ? Q_PI_2 : Q_3PI_2;
		end else if (re_l > 0 && im_l > 0) begin
			theta = z;
		end else if (re_l < 0 && im_l > 0) begin
			theta = Q_PI - z;
		end else if (re_l < 0) begin
			theta = Q_PI + z;
		end else begin
			theta = Q_2PI - z;
		end
		pr = (64'(theta) + (64'd1 << 14)) >> 15;
		if (pr > 64'(PH_TOP)) begin
			pr = 64'd0;
		end
		r.re = re;
		r.im = im;
		r.mag = prod[MAG_W-1:0];
		r.ph = pr[PH_W-1:0];
		return r;
	endfunction

	function automatic int idle_pct();
		if (n_sent + 200 >= n_total) begin
			return 0;
		end
		case ((n_sent / 150) % 3)
			0: return 0;
			1: return 8;
			default: return 30;
		endcase
	endfunction

	function automatic logic signed [IN_W-1:0] pick_extreme();
		case ($urandom_range(0, 5))
			0: return -16'sd32768;
			1: return -16'sd32767;
			2: return -16'sd1;
			3: return 16'sd0;
			4: return 16'sd1;
			default: return 16'sd32767;
		endcase
	endfunction

	function automatic sample_t random_sample();
		sample_t s;
		int      v;
		s.drain = 1'b0;
		s.re = 16'($urandom_range(0, 65535));
		s.im = 16'($urandom_range(0, 65535));
		case ($urandom_range(0, 9))
			5: begin
				v = int'($urandom_range(0, 127)) - 64;
				s.re = v[15:0];
				v = int'($urandom_range(0, 127)) - 64;
				s.im = v[15:0];
			end
			6: begin
				v = int'($urandom_range(0, 6)) - 3;
				s.im = v[15:0];
			end
			7: begin
				v = int'($urandom_range(0, 6)) - 3;
				s.re = v[15:0];
			end
			8: begin
				s.re = pick_extreme();
				s.im = pick_extreme();
			end
			9: begin
				s.im = $urandom_range(0, 1) ? s.re : -s.re;
			end
			default: begin
			end
		endcase
		return s;
	endfunction

	task automatic add_pair(input int re, input int im);
		sample_t s;
		s.re = re[15:0];
		s.im = im[15:0];
		s.drain = 1'b0;
		pending_samples.push_back(s);
		n_total++;
	endtask

	task automatic add_drain();
		sample_t s;
		s.re = '0;
		s.im = '0;
		s.drain = 1'b1;
		pending_samples.push_back(s);
	endtask

	// stimulus and end of run
	initial begin
		inv_gain = cordic_inv_gain(USED_STAGE);
		add_pair(0, 0);
		add_pair(32767, 0);
		add_pair(-32768, 0);
		add_pair(0, 32767);
		add_pair(0, -32768);
		add_pair(32767, 32767);
		add_pair(-32768, 32767);
		add_pair(-32768, -32768);
		add_pair(32767, -32768);
		add_pair(1, 0);
		add_pair(-1, 0);
		add_pair(0, 1);
		add_pair(0, -1);
		add_pair(1, 1);
		add_pair(-1, 1);
		add_pair(-1, -1);
		add_pair(1, -1);
		add_pair(32767, -1);
		add_pair(-32768, -1);
		add_pair(-32768, 1);
		add_pair(3, 4);
		add_pair(-100, -1);
		add_pair(32767, 1);
		add_drain();
		for (int k = 0; k < 1380; k++) begin
			if (k == 500 || k == 900) begin
				add_drain();
			end
			pending_samples.push_back(random_sample());
			n_total++;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (pending_samples.size() != 0 || sample_valid || awaited_polar.size() != 0) begin
			@(posedge clk);
		end
		repeat (LATENCY + 8) @(posedge clk);
		$display("Converted %0d sample pairs, %0d results checked, %0d drain pauses.",
			n_in, n_out, n_drains);
		$display("Covered origin, axes, all quadrants, full-scale and wrap corners.");
		if (n_err == 0) begin
			$display("** complex_to_polar_impedance_unit: PASSED **");
		end else begin
			$display("** complex_to_polar_impedance_unit: FAILED **");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Timeout with %0d results still outstanding", awaited_polar.size());
		$display("** complex_to_polar_impedance_unit: FAILED **");
		$finish;
	end

	// sender
	always @(negedge clk) begin : drv
		sample_t s;
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else if (sample_valid && !in_took) begin
			// stalled transaction stays put
		end else if (in_gap > 0) begin
			in_gap = in_gap - 1;
			sample_valid <= 1'b0;
		end else if (pending_samples.size() == 0) begin
			sample_valid <= 1'b0;
		end else if (pending_samples[0].drain) begin
			if (awaited_polar.size() == 0) begin
				s = pending_samples.pop_front();
				n_drains++;
			end
			sample_valid <= 1'b0;
		end else if (idle_pct() > 0 && $urandom_range(1, 100) <= idle_pct()) begin
			in_gap = $urandom_range(1, 13) - 1;
			sample_valid <= 1'b0;
		end else begin
			s = pending_samples.pop_front();
			sample_valid <= 1'b1;
			real_part <= s.re;
			imag_part <= s.im;
			n_sent++;
		end
	end

	// receiver stall
	always @(negedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
			result_stall <= 1'b1;
		end else if (!hold_done && n_in >= 300) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYC - 1;
			result_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left = stall_left - 1;
			result_stall <= 1'b1;
		end else if (idle_pct() > 0 && $urandom_range(1, 100) <= idle_pct()) begin
			stall_left = $urandom_range(1, 13) - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// monitor and scoreboard
	always @(posedge clk) begin : mon
		polar_t w;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (awaited_polar.size() == 0) begin
					$display("%0t: unexpected transaction mag=%0d phase=%0d",
						$time, magnitude, phase);
					n_err++;
				end else begin
					w = awaited_polar.pop_front();
					n_out++;
					if (magnitude !== w.mag) begin
						$display("%0t: re=%0d im=%0d magnitude expected %0d actual %0d",
							$time, w.re, w.im, w.mag, magnitude);
						n_err++;
					end
					if (phase !== w.ph) begin
						$display("%0t: re=%0d im=%0d phase expected %0d actual %0d",
							$time, w.re, w.im, w.ph, phase);
						n_err++;
					end
				end
			end
			if (sample_valid && !sample_stall) begin
				awaited_polar.push_back(polar_of(real_part, imag_part));
				n_in++;
			end
		end
		in_took <= arst_n && sample_valid && !sample_stall;
	end

endmodule
